// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define TRPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define TRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/trpd_pkg.sv =====
`default_nettype none

package trpd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned SIZE_W     = 13;   // width and height registers
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

    // bytes per pixel
    localparam logic [2:0] PB_INDEX = 3'd1;
    localparam logic [2:0] PB_555   = 3'd2;
    localparam logic [2:0] PB_BGR   = 3'd3;
    localparam logic [2:0] PB_BGRA  = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic              rle;
        logic              top_down;
        logic [2:0]        pixel_bytes;   // already limited to 1..4
        logic [SIZE_W-1:0] width;         // 1..max
        logic [SIZE_W-1:0] height_m1;     // rows minus one
    } t_cfg;

    // one finished pixel or run, handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] pixel_index;
        logic [7:0] rep;        // pixels asked for before clipping
        logic       is_run;
        logic       pkt_end;    // last pixel of its packet
    } t_pix;

endpackage

`default_nettype wire

// ===== hw/rtl/trpd_front.sv =====
`default_nettype none

module trpd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_restart,
    input  trpd_pkg::t_cfg     i_cfg,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_q_full,
    output logic               o_push,
    output trpd_pkg::t_pix     o_pix
);
    import trpd_pkg::*;

    logic [7:0]      r_left;
    logic            r_is_run;
    logic [1:0]      r_bpos;
    logic [3:0][7:0] r_gather;

    logic [7:0] n_left;
    logic       n_is_run;
    logic [1:0] n_bpos;
    logic       accept;
    logic       header;
    logic       done;
    logic [15:0] c16;

    assign accept = i_valid && !i_q_full;
    assign header = i_cfg.rle && (r_left == 8'd0);
    assign done   = ({1'b0, r_bpos} + 3'd1) == i_cfg.pixel_bytes;
    assign o_push = accept && !header && done;
    assign c16    = {i_data, r_gather[0]};

    always_comb begin
        o_pix             = '0;
        o_pix.alpha       = ALPHA_OPAQUE;
        o_pix.is_run      = r_is_run;
        o_pix.pkt_end     = r_is_run || (r_left == 8'd1);
        o_pix.rep         = (i_cfg.rle && r_is_run) ? r_left : 8'd1;
        unique case (i_cfg.pixel_bytes)
            PB_INDEX: o_pix.pixel_index = i_data;
            PB_555: begin
                o_pix.red   = {c16[14:10], 3'b000};
                o_pix.green = {c16[9:5], 3'b000};
                o_pix.blue  = {c16[4:0], 3'b000};
            end
            PB_BGR: begin
                o_pix.blue  = r_gather[0];
                o_pix.green = r_gather[1];
                o_pix.red   = i_data;
            end
            PB_BGRA: begin
                o_pix.blue  = r_gather[0];
                o_pix.green = r_gather[1];
                o_pix.red   = r_gather[2];
                o_pix.alpha = i_data;
            end
            default: o_pix.pixel_index = i_data;
        endcase
    end

    always_comb begin
        n_left   = r_left;
        n_is_run = r_is_run;
        n_bpos   = r_bpos;
        if (accept) begin
            if (header) begin
                n_is_run = i_data[7];
                n_left   = {1'b0, i_data[6:0]} + 8'd1;
                n_bpos   = '0;
            end else if (done) begin
                n_bpos = '0;
                if (i_cfg.rle) begin
                    n_left = r_is_run ? 8'd0 : 8'(r_left - 8'd1);
                end
            end else begin
                n_bpos = 2'(r_bpos + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_left   <= '0;
            r_is_run <= 1'b0;
            r_bpos   <= '0;
        end else begin
            r_left   <= n_left;
            r_is_run <= n_is_run;
            r_bpos   <= n_bpos;
        end
    end

    // gathered bytes need no reset: only bytes of the current pixel are read
    always_ff @(posedge i_clk) begin
        if (accept && !header) begin
            r_gather[r_bpos] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trpd_queue.sv =====
`default_nettype none

module trpd_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_flush,
    input  wire logic      i_push,
    input  trpd_pkg::t_pix i_pix,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_pop,
    output trpd_pkg::t_pix o_pix
);
    import trpd_pkg::*;

    t_pix              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_pix   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= QPTR_W'(r_wr + 1'b1);
            if (do_pop)  r_rd <= QPTR_W'(r_rd + 1'b1);
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pix;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trpd_back.sv =====
`default_nettype none

module trpd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_restart,
    input  trpd_pkg::t_cfg     i_cfg,
    input  wire logic          i_q_valid,
    input  trpd_pkg::t_pix     i_pix,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic [7:0]         o_pixel_index,
    output logic [7:0]         o_repeat_res,
    output logic [11:0]        o_start_column,
    output logic [11:0]        o_dest_row,
    output logic               o_last
);
    import trpd_pkg::*;

    logic [SIZE_W-1:0] r_col;
    logic [SIZE_W-1:0] r_row;
    logic              r_valid;

    logic [SIZE_W:0]   sum;
    logic              over;
    logic              emit;
    logic [SIZE_W-1:0] col_new;
    logic [7:0]        rep_c;
    logic              row_end;
    logic              row_adv;
    logic              row_last;
    logic [SIZE_W-1:0] n_col;
    logic [SIZE_W-1:0] n_row;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    assign sum      = {1'b0, r_col} + (SIZE_W+1)'(i_pix.rep);
    assign over     = sum > {1'b0, i_cfg.width};
    // literal pixels past the row end are swallowed
    assign emit     = !(i_cfg.rle && !i_pix.is_run && (r_col >= i_cfg.width));
    assign col_new  = !emit ? r_col : (over ? i_cfg.width : sum[SIZE_W-1:0]);
    assign rep_c    = over ? 8'(i_cfg.width - r_col) : i_pix.rep;
    assign row_end  = col_new >= i_cfg.width;
    assign row_adv  = row_end && (!i_cfg.rle || i_pix.pkt_end);
    assign row_last = r_row >= i_cfg.height_m1;

    always_comb begin
        n_col = col_new;
        n_row = r_row;
        if (row_adv) begin
            n_col = '0;
            n_row = row_last ? '0 : SIZE_W'(r_row + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_valid <= emit;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            o_red          <= i_pix.red;
            o_green        <= i_pix.green;
            o_blue         <= i_pix.blue;
            o_alpha        <= i_pix.alpha;
            o_pixel_index  <= i_pix.pixel_index;
            o_repeat_res   <= rep_c;
            o_start_column <= r_col[11:0];
            o_dest_row     <= i_cfg.top_down ? r_row[11:0]
                                             : 12'(i_cfg.height_m1 - r_row);
            o_last         <= row_end && row_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_pixel_decoder_top.sv =====
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_stall     i_data_byte
// out       output     o_out_valid / i_out_stall   colour, index, span, row, last
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_in_stall is low; a span moves from front
// to queue to output register; one span per cycle while i_out_stall is low.
// Reset and a valid write to index 0..4 restart the decoder at a new image.
// o_in_stall rises only while the four-entry pixel queue is full.
// o_cfg_ready is always high.
`default_nettype none

module tga_rle_pixel_decoder_top #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [7:0]                 i_data_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_alpha,
    output logic [7:0]                      o_pixel_index,
    output logic [7:0]                      o_repeat_res,
    output logic [11:0]                     o_start_column,
    output logic [11:0]                     o_dest_row,
    output logic                            o_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [trpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [trpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import trpd_pkg::*;

`include "assert_macros.svh"

    logic [2:0]        r_pixel_bytes;
    logic              r_rle_enable;
    logic              r_top_down;
    logic [SIZE_W-1:0] r_image_width;
    logic [SIZE_W-1:0] r_image_height;

    logic              cfg_write;
    logic              restart;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    t_cfg              cfg;

    logic front_push;
    t_pix front_pix;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_pix q_pix;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_write && (i_cfg_index <= CFG_IMAGE_HEIGHT);
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes  <= 3'd1;
            r_rle_enable   <= 1'b0;
            r_top_down     <= 1'b0;
            r_image_width  <= SIZE_W'(1);
            r_image_height <= SIZE_W'(1);
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_PIXEL_BYTES:  r_pixel_bytes  <= i_cfg_data[2:0];
                CFG_RLE_ENABLE:   r_rle_enable   <= i_cfg_data[0];
                CFG_TOP_DOWN:     r_top_down     <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes: zero acts as one, large values saturate
    always_comb begin
        priority if (r_image_width == '0)          width_eff = SIZE_W'(1);
        else if (32'(r_image_width) > MAX_WIDTH)   width_eff = SIZE_W'(MAX_WIDTH);
        else                                       width_eff = r_image_width;
        priority if (r_image_height == '0)         height_eff = SIZE_W'(1);
        else if (32'(r_image_height) > MAX_HEIGHT) height_eff = SIZE_W'(MAX_HEIGHT);
        else                                       height_eff = r_image_height;
    end

    always_comb begin
        cfg.rle       = r_rle_enable;
        cfg.top_down  = r_top_down;
        cfg.width     = width_eff;
        cfg.height_m1 = SIZE_W'(height_eff - 1'b1);
        priority if (r_pixel_bytes == 3'd0)  cfg.pixel_bytes = PB_INDEX;
        else if (r_pixel_bytes > PB_BGRA)    cfg.pixel_bytes = PB_BGRA;
        else                                 cfg.pixel_bytes = r_pixel_bytes;
    end

    trpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_restart(restart),
        .i_cfg    (cfg),
        .i_valid  (i_in_valid),
        .i_data   (i_data_byte),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_pix    (front_pix)
    );

    trpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flush(restart),
        .i_push (front_push),
        .i_pix  (front_pix),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_pix  (q_pix)
    );

    trpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_pix         (q_pix),
        .o_pop         (q_pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_pixel_index (o_pixel_index),
        .o_repeat_res  (o_repeat_res),
        .o_start_column(o_start_column),
        .o_dest_row    (o_dest_row),
        .o_last        (o_last)
    );

    `TRPD_ASSERT_IMPL(a_no_push_when_full, front_push, !q_full, "pixel pushed into full queue")
    `TRPD_ASSERT_NEXT(a_restart_clears, restart, !o_out_valid && !q_valid, "state left after restart")
    `TRPD_ASSERT_IMPL(a_span_nonzero, o_out_valid, o_repeat_res != 8'd0, "span of zero pixels")

endmodule

`default_nettype wire

// ===== tb/tga_rle_pixel_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_top_tb;
    import trpd_pkg::*;

    localparam int unsigned MAX_W         = 4096;
    localparam int unsigned MAX_H         = 4096;
    localparam int          RANDOM_BYTES  = 1000;
    localparam int          QUIET_BYTES   = 150;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          LONG_HOLD     = 80;
    localparam int          TIMEOUT_NS    = 800_000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 3'd6;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  pixel_index;
        logic [7:0]  repeat_res;
        logic [11:0] start_column;
        logic [11:0] dest_row;
        logic        last;
    } span_t;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    typed;
        span_t                 span;
    } dir_row_t;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [7:0]            i_data_byte  = 8'd0;
    logic                  i_out_stall  = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_PIXEL_BYTES;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic [7:0]            o_alpha;
    logic [7:0]            o_pixel_index;
    logic [7:0]            o_repeat_res;
    logic [11:0]           o_start_column;
    logic [11:0]           o_dest_row;
    logic                  o_last;

    tga_rle_pixel_decoder_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_pixel_index  (o_pixel_index),
        .o_repeat_res   (o_repeat_res),
        .o_start_column (o_start_column),
        .o_dest_row     (o_dest_row),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decoder mirror: registers
    logic [2:0]  cfg_pix_bytes;
    logic        cfg_rle;
    logic        cfg_top_down;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    // decoder mirror: stream position
    logic        st_want_header;
    logic        st_run;
    logic [7:0]  st_left;
    logic [1:0]  st_byte_pos;
    logic [31:0] st_gather;
    logic [12:0] st_col;
    logic [11:0] st_row;

    span_t    span_q[$];
    dir_row_t dir_rows[$];
    int       fault_count   = 0;
    int       spans_checked = 0;
    int       bytes_sent    = 0;
    int       settings_used = 0;
    bit       hold_toggle   = 1'b0;
    bit       quiet_tail    = 1'b0;
    string    field_names[9] = '{"red", "green", "blue", "alpha", "pixel_index",
                                 "repeat_res", "start_column", "dest_row", "last"};

    function automatic void restart_image();
        st_want_header = cfg_rle;
        st_run         = 1'b0;
        st_left        = '0;
        st_byte_pos    = '0;
        st_gather      = '0;
        st_col         = '0;
        st_row         = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PIXEL_BYTES:  cfg_pix_bytes = val[2:0];
            CFG_RLE_ENABLE:   cfg_rle       = val[0];
            CFG_TOP_DOWN:     cfg_top_down  = val[0];
            CFG_IMAGE_WIDTH:  cfg_width     = val[12:0];
            CFG_IMAGE_HEIGHT: cfg_height    = val[12:0];
            default:          return;
        endcase
        restart_image();
    endfunction

    function automatic int unsigned clamp_size(input logic [12:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return 32'(v);
    endfunction

    function automatic void advance_row(input int unsigned h);
        st_col = '0;
        st_row = (st_row + 1 >= h) ? 12'd0 : st_row + 12'd1;
    endfunction

    // returns 1 when the byte completes a span
    function automatic bit decode_byte(input logic [7:0] b, output span_t sp);
        logic [2:0]  pb;
        int unsigned w, h, rep, col, row, drow;
        bit          show;
        sp       = '0;
        sp.alpha = ALPHA_OPAQUE;
        pb = (cfg_pix_bytes == 0) ? PB_INDEX :
             (cfg_pix_bytes > PB_BGRA) ? PB_BGRA : cfg_pix_bytes;
        w  = clamp_size(cfg_width, MAX_W);
        h  = clamp_size(cfg_height, MAX_H);

        if (cfg_rle && st_want_header) begin
            st_run         = b[7];
            st_left        = {1'b0, b[6:0]} + 8'd1;
            st_want_header = 1'b0;
            st_byte_pos    = '0;
            st_gather      = '0;
            return 1'b0;
        end

        st_gather   = st_gather | ({24'd0, b} << (8 * st_byte_pos));
        st_byte_pos = st_byte_pos + 2'd1;
        if (st_byte_pos != 0 && {1'b0, st_byte_pos} < pb) return 1'b0;
        st_byte_pos = '0;

        case (pb)
            PB_INDEX: sp.pixel_index = st_gather[7:0];
            PB_555: begin
                sp.red   = {st_gather[14:10], 3'b000};
                sp.green = {st_gather[9:5], 3'b000};
                sp.blue  = {st_gather[4:0], 3'b000};
            end
            default: begin
                sp.blue  = st_gather[7:0];
                sp.green = st_gather[15:8];
                sp.red   = st_gather[23:16];
                if (pb == PB_BGRA) sp.alpha = st_gather[31:24];
            end
        endcase
        st_gather = '0;

        col  = 32'(st_col);
        row  = 32'(st_row);
        rep  = 1;
        show = 1'b1;
        if (cfg_rle) begin
            if (st_run) begin
                rep = 32'(st_left);
                // clip the run at the row end
                if (col + rep > w) rep = w - col;
                st_left = '0;
            end else begin
                // literals past the row end are swallowed
                if (col >= w) show = 1'b0;
                if (st_left > 0) st_left = st_left - 8'd1;
            end
        end
        if (show) st_col = 13'(col + rep);
        sp.last = show && st_col >= w && row + 1 >= h;

        if (cfg_rle) begin
            if (st_left == 0) begin
                st_want_header = 1'b1;
                if (st_col >= w) advance_row(h);
            end
        end else if (st_col >= w) begin
            advance_row(h);
        end

        drow            = cfg_top_down ? row : h - 1 - row;
        sp.repeat_res   = rep[7:0];
        sp.start_column = col[11:0];
        sp.dest_row     = drow[11:0];
        return show;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        span_t sp;
        if (decode_byte(b, sp)) span_q.push_back(sp);
    endfunction

    function automatic span_t mk_span(input logic [7:0] r, g, bl, a, ix, rep,
                                      input logic [11:0] col, row, input logic lst);
        mk_span = '{r, g, bl, a, ix, rep, col, row, lst};
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        dir_row_t row;
        row        = '{default: '0};
        row.val    = {5'd0, b};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_byte_exp(input logic [7:0] b, input span_t sp);
        dir_row_t row;
        row        = '{default: '0};
        row.val    = {5'd0, b};
        row.typed  = 1'b1;
        row.span   = sp;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row        = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < 10) $display("mismatch: %s", msg);
        fault_count++;
    endfunction

    function automatic int pick_gap(input bit on);
        if (on && $urandom_range(0, 4) == 0) return $urandom_range(1, 6);
        return 0;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // drop valid, drain every pending span, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: check each span transfer, stall in bursts
    int hold_left  = 0;
    int stall_left = 0;
    int mood_left  = 0;
    bit stall_on   = 1'b1;
    bit hold_seen  = 1'b0;

    always @(posedge i_clk) begin
        logic [11:0] got_v[9];
        logic [11:0] want_v[9];
        span_t       want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_v = '{o_red, o_green, o_blue, o_alpha, o_pixel_index, o_repeat_res,
                          o_start_column, o_dest_row, o_last};
                if (span_q.size() == 0) begin
                    note_fault($sformatf("unexpected span at column %0d, row %0d",
                                         o_start_column, o_dest_row));
                end else begin
                    want   = span_q.pop_front();
                    want_v = '{want.red, want.green, want.blue, want.alpha, want.pixel_index,
                               want.repeat_res, want.start_column, want.dest_row, want.last};
                    spans_checked++;
                    for (int k = 0; k < 9; k++) begin
                        if (got_v[k] !== want_v[k])
                            note_fault($sformatf("span %0d %s: expected %0d, got %0d",
                                                 spans_checked, field_names[k],
                                                 want_v[k], got_v[k]));
                    end
                end
            end

            if (hold_seen != hold_toggle) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            if (mood_left == 0) begin
                stall_on  = $urandom_range(0, 2) != 0;
                mood_left = $urandom_range(20, 200);
            end else begin
                mood_left--;
            end

            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : main_seq
        span_t       sp;
        logic [7:0]  burst[$];
        logic [2:0]  pb_val;
        logic        rle_val;
        logic        top_val;
        logic [12:0] w_val;
        logic [12:0] h_val;
        logic [6:0]  count;
        bit          is_run;
        bit          pressure;
        bit          tail;
        bit          gaps_on;
        int          eff_pb;
        int          budget;
        int          phase_bytes;
        int          phase_no;
        int          stop_at;

        cfg_pix_bytes = PB_INDEX;
        cfg_rle       = 1'b0;
        cfg_top_down  = 1'b0;
        cfg_width     = 13'd1;
        cfg_height    = 13'd1;
        restart_image();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-pixel image straight after reset
        add_byte_exp(8'h00, mk_span(0, 0, 0, ALPHA_OPAQUE, 8'h00, 1, 0, 0, 1));
        add_byte_exp(8'hFF, mk_span(0, 0, 0, ALPHA_OPAQUE, 8'hFF, 1, 0, 0, 1));
        // 5:5:5 on a 2x2 image, bottom-up
        add_reg(CFG_PIXEL_BYTES, PB_555);
        add_reg(CFG_IMAGE_WIDTH, 13'd2);
        add_reg(CFG_IMAGE_HEIGHT, 13'd2);
        add_byte(8'hFF);
        add_byte_exp(8'h7F, mk_span(8'hF8, 8'hF8, 8'hF8, ALPHA_OPAQUE, 0, 1, 0, 1, 0));
        add_byte(8'h00);
        add_byte_exp(8'h80, mk_span(0, 0, 0, ALPHA_OPAQUE, 0, 1, 1, 1, 0));
        add_byte(8'h55);
        add_byte(8'h2A);
        // BGR, with an unmapped register write in the middle of a pixel
        add_reg(CFG_PIXEL_BYTES, PB_BGR);
        add_byte(8'h01);
        add_byte(8'h02);
        add_reg(CFG_IDX_UNMAPPED, '1);
        add_byte_exp(8'h03, mk_span(8'h03, 8'h02, 8'h01, ALPHA_OPAQUE, 0, 1, 0, 1, 0));
        // BGRA with zero alpha
        add_reg(CFG_PIXEL_BYTES, PB_BGRA);
        add_byte(8'h10);
        add_byte(8'h20);
        add_byte(8'h30);
        add_byte_exp(8'h00, mk_span(8'h30, 8'h20, 8'h10, 8'h00, 0, 1, 0, 1, 0));
        // RLE, top-down, width 2, zero height acting as one row
        add_reg(CFG_RLE_ENABLE, 13'd1);
        add_reg(CFG_TOP_DOWN, 13'd1);
        add_reg(CFG_PIXEL_BYTES, PB_INDEX);
        add_reg(CFG_IMAGE_HEIGHT, 13'd0);
        add_byte(8'h85);
        add_byte_exp(8'h5A, mk_span(0, 0, 0, ALPHA_OPAQUE, 8'h5A, 2, 0, 0, 1));
        // three literals into a two-pixel row: the third is dropped
        add_byte(8'h02);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        // longest run, clipped
        add_byte(8'hFF);
        add_byte(8'hC3);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
                i_cfg_valid <= 1'b0;
                settings_used++;
            end else begin
                send_byte(dir_rows[i].val[7:0], pick_gap(1'b1));
                if (dir_rows[i].typed) begin
                    void'(decode_byte(dir_rows[i].val[7:0], sp));
                    span_q.push_back(dir_rows[i].span);
                end else begin
                    predict_byte(dir_rows[i].val[7:0]);
                end
            end
        end

        stop_at  = bytes_sent + RANDOM_BYTES;
        phase_no = 0;
        tail     = 1'b0;
        while (bytes_sent < stop_at) begin
            wait_idle();
            pressure = (phase_no == 1);
            if (bytes_sent + QUIET_BYTES >= stop_at) begin
                tail = 1'b1;
                quiet_tail <= 1'b1;
            end

            case ($urandom_range(0, 9))
                0:       pb_val = 3'd0;
                1:       pb_val = 3'($urandom_range(int'(PB_BGRA) + 1, 7));
                default: pb_val = 3'($urandom_range(int'(PB_INDEX), int'(PB_BGRA)));
            endcase
            rle_val = $urandom_range(0, 3) != 0;
            top_val = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0:       w_val = '0;
                1:       w_val = 13'd4096;
                2:       w_val = 13'($urandom_range(4097, 8191));
                3:       w_val = '1;
                default: w_val = 13'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 19))
                0:       h_val = '0;
                1:       h_val = 13'd4096;
                2:       h_val = 13'd4095;
                3:       h_val = '1;
                default: h_val = 13'($urandom_range(1, 4));
            endcase
            // flood the output queue: raw one-byte pixels, no gaps, long output hold
            if (pressure) begin
                pb_val  = PB_INDEX;
                rle_val = 1'b0;
                w_val   = 13'd4;
            end

            write_reg(CFG_PIXEL_BYTES, {10'd0, pb_val});
            write_reg(CFG_RLE_ENABLE, {12'd0, rle_val});
            write_reg(CFG_TOP_DOWN, {12'd0, top_val});
            write_reg(CFG_IMAGE_WIDTH, w_val);
            write_reg(CFG_IMAGE_HEIGHT, h_val);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_IMAGE_HEIGHT) + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            i_cfg_valid <= 1'b0;
            settings_used++;
            if (pressure) hold_toggle <= !hold_toggle;

            gaps_on     = !pressure && !tail && $urandom_range(0, 3) != 0;
            budget      = pressure ? 120 : $urandom_range(40, 120);
            eff_pb      = (pb_val == 0) ? 1 : (pb_val > PB_BGRA) ? 4 : pb_val;
            phase_bytes = 0;
            while (phase_bytes < budget) begin
                burst.delete();
                if (!rle_val || $urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4)) burst.push_back(rand_byte());
                end else begin
                    is_run = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 15))
                        0:       count = 7'd127;
                        1:       count = 7'($urandom_range(0, 127));
                        default: count = 7'($urandom_range(0, 7));
                    endcase
                    if (!is_run && eff_pb > 1 && count > 15) count = 7'($urandom_range(8, 15));
                    burst.push_back({is_run, count});
                    repeat ((is_run ? 1 : count + 1) * eff_pb) burst.push_back(rand_byte());
                end
                foreach (burst[i]) begin
                    // phase end may cut a packet short
                    if (phase_bytes >= budget) break;
                    if (phase_bytes == budget / 2 && !pressure && !tail) wait_idle();
                    send_byte(burst[i], pick_gap(gaps_on));
                    predict_byte(burst[i]);
                    phase_bytes++;
                end
            end
            phase_no++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Fed %0d bytes under %0d register settings; checked %0d spans.",
                 bytes_sent, settings_used, spans_checked);
        $display("Covered 1-4 byte pixels, raw and RLE streams, clipping, row flips, holds.");
        if (fault_count == 0 && span_q.size() == 0) begin
            $display("PASS tga_rle_pixel_decoder_top");
        end else begin
            $display("FAIL tga_rle_pixel_decoder_top");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL tga_rle_pixel_decoder_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/trpd_pkg.sv
hw/rtl/trpd_front.sv
hw/rtl/trpd_queue.sv
hw/rtl/trpd_back.sv
hw/rtl/tga_rle_pixel_decoder_top.sv
tb/tga_rle_pixel_decoder_top_tb.sv
